// ===== rtl/core/separable_convolution_filter_assert.svh =====
// Assertion macros shared by the separable convolution filter RTL.
`ifndef SEPARABLE_CONVOLUTION_FILTER_ASSERT_SVH
`define SEPARABLE_CONVOLUTION_FILTER_ASSERT_SVH

// same-cycle implication
`define SCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scf_pkg.sv =====
// Shared types and constants of the separable convolution filter.
`default_nettype none
package scf_pkg;

  localparam int KSIZE     = 7;
  localparam int MAX_WIDTH = 1024;
  localparam int STORE_DEPTH = KSIZE * MAX_WIDTH;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam logic [2:0] CFG_WIDTH = 3'd0;
  localparam logic [2:0] CFG_TAP0  = 3'd1;

  typedef logic signed [15:0] tap_t;
  typedef tap_t [KSIZE-1:0] tap_vec_t;
  typedef logic [KSIZE-1:0][7:0] pix_vec_t;

  // one unit of back-end work: optional row filter plus store write,
  // optional column filter producing one result word
  typedef struct packed {
    logic       do_h;
    logic       do_v;
    pix_vec_t   hpix;
    logic [9:0] x;
    logic [2:0] slot;
    logic [1:0] base;
    logic [2:0] top;
    logic       run_last;
    logic       frame_last;
  } job_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       run_last;
    logic       frame_last;
  } out_word_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HMAC,
    B_HWR,
    B_VMAC,
    B_VOUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/separable_convolution_filter.sv =====
// Top level of the separable 7-tap convolution filter.
//
//  channel   dir  handshake            fields
//  input     in   push / full          in_req_type, in_pixel_in, in_end_of_frame
//  result    out  pop / empty          out_pixel_out, out_run_last, out_frame_last
//  config    in   cfg_we               cfg_index, cfg_data
//
// Throughput is set by the single accumulator in the back end, shared by the row
// and column filters and adding one tap per cycle, and by the one read port of
// the line store. Reset is synchronous, active low. full stays high while the
// front end issues jobs for a pixel or the job queue is full; a stalled result
// queue stops the back end, and the input only once the job queue is full.
`default_nettype none
module separable_convolution_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_pixel_in,
  input  wire logic        in_end_of_frame,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_pixel_out,
  output logic             out_run_last,
  output logic             out_frame_last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [10:0] width_r;
  scf_pkg::tap_vec_t taps_r;
  logic [10:0] width_eff;

  logic q_full, q_empty, q_push, q_pop;
  scf_pkg::job_t q_wjob, q_rjob;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd512;
      // center tap at unity, all others zero
      taps_r  <= {48'd0, 16'd16384, 48'd0};
    end else if (cfg_we) begin
      if (cfg_index == scf_pkg::CFG_WIDTH) width_r <= cfg_data[10:0];
      else taps_r[cfg_index - scf_pkg::CFG_TAP0] <= cfg_data;
    end
  end

  always_comb begin
    if (width_r == 11'd0)                          width_eff = 11'd1;
    else if (width_r > 11'(scf_pkg::MAX_WIDTH))    width_eff = 11'(scf_pkg::MAX_WIDTH);
    else                                           width_eff = width_r;
  end

  scf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_pixel_in     (in_pixel_in),
    .in_end_of_frame (in_end_of_frame),
    .width           (width_eff),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_wjob)
  );

  scf_job_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wjob  (q_wjob),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_rjob  (q_rjob),
    .q_empty (q_empty)
  );

  scf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .taps           (taps_r),
    .q_empty        (q_empty),
    .q_job          (q_rjob),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_pixel_out  (out_pixel_out),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule
`default_nettype wire

// ===== rtl/core/scf_front.sv =====
// Front end: takes input words, tracks raster position and drain, issues jobs.
`default_nettype none
module scf_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             in_req_type,
  input  wire logic [7:0]       in_pixel_in,
  input  wire logic             in_end_of_frame,
  input  wire logic [10:0]      width,
  input  wire logic             q_full,
  output logic                  q_push,
  output scf_pkg::job_t         q_job
);

  scf_pkg::pix_vec_t win_r, win_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [2:0]  rows_r, rows_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [9:0]  ocol_r, ocol_nxt;
  logic [11:0] dleft_r, dleft_nxt;
  logic [1:0]  drow_r, drow_nxt;
  logic        fover_r, fover_nxt;
  logic        busy_r, busy_nxt;
  logic [9:0]  pc_r, pc_nxt;
  logic [1:0]  ps_r, ps_nxt;
  logic [1:0]  psmax_r, psmax_nxt;
  logic [2:0]  pslot_r, pslot_nxt;
  logic [2:0]  prows_r, prows_nxt;

  logic        accept;
  logic [9:0]  col_e;
  logic [2:0]  rows_e, slot_e;
  logic [10:0] c_inc, ocol_inc;
  logic        last;
  logic [1:0]  rows_dr;
  logic [11:0] drain_total;
  logic signed [11:0] xs;
  scf_pkg::pix_vec_t hpix;

  assign full   = busy_r | q_full;
  assign accept = push & ~full;

  always_comb begin
    int kk;
    kk = 0;
    for (int i = 0; i < scf_pkg::KSIZE; i++) begin
      kk = scf_pkg::KSIZE - 1 - i - int'(ps_r);
      if (kk < 0) kk = 0;
      hpix[i] = win_r[kk[2:0]];
    end
  end

  always_comb begin
    // a pixel after a finished frame starts the next one
    col_e  = fover_r ? 10'd0 : col_r;
    rows_e = fover_r ? 3'd0 : rows_r;
    slot_e = fover_r ? 3'd0 : slot_r;
    c_inc  = {1'b0, col_e} + 11'd1;
    last   = c_inc >= width;
    rows_dr = (rows_e >= 3'd2) ? 2'd3 : (rows_e[1:0] + 2'd1);
    case (rows_dr)
      2'd1:    drain_total = {1'b0, width};
      2'd2:    drain_total = {width, 1'b0};
      default: drain_total = {1'b0, width} + {width, 1'b0};
    endcase
    ocol_inc = {1'b0, ocol_r} + 11'd1;
    xs = $signed({2'b00, pc_r}) - 12'sd3 + $signed({10'd0, ps_r});
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = '0;
    if (busy_r) begin
      q_push           = ~xs[11] & ~q_full;
      q_job.do_h       = 1'b1;
      q_job.do_v       = prows_r >= 3'd3;
      q_job.hpix       = hpix;
      q_job.x          = xs[9:0];
      q_job.slot       = pslot_r;
      q_job.base       = 2'd3;
      q_job.top        = prows_r;
      q_job.run_last   = ps_r == psmax_r;
      q_job.frame_last = 1'b0;
    end else begin
      q_push           = accept & (in_req_type == scf_pkg::REQ_DRAIN) & (dleft_r != 12'd0);
      q_job.do_h       = 1'b0;
      q_job.do_v       = 1'b1;
      q_job.hpix       = win_r;
      q_job.x          = ocol_r;
      q_job.slot       = slot_r;
      q_job.base       = drow_r;
      q_job.top        = rows_r;
      q_job.run_last   = 1'b1;
      q_job.frame_last = dleft_r == 12'd1;
    end
  end

  always_comb begin
    win_nxt   = win_r;
    col_nxt   = col_r;
    rows_nxt  = rows_r;
    slot_nxt  = slot_r;
    ocol_nxt  = ocol_r;
    dleft_nxt = dleft_r;
    drow_nxt  = drow_r;
    fover_nxt = fover_r;
    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    ps_nxt    = ps_r;
    psmax_nxt = psmax_r;
    pslot_nxt = pslot_r;
    prows_nxt = prows_r;

    if (busy_r && !q_full) begin
      if (ps_r == psmax_r) busy_nxt = 1'b0;
      else ps_nxt = ps_r + 2'd1;
    end

    if (accept) begin
      if (in_req_type == scf_pkg::REQ_PIXEL) begin
        if (col_e == 10'd0) begin
          for (int k = 0; k < scf_pkg::KSIZE; k++) win_nxt[k] = in_pixel_in;
        end else begin
          for (int k = scf_pkg::KSIZE - 1; k > 0; k--) win_nxt[k] = win_r[k-1];
          win_nxt[0] = in_pixel_in;
        end
        busy_nxt  = 1'b1;
        ps_nxt    = 2'd0;
        psmax_nxt = last ? 2'd3 : 2'd0;
        pc_nxt    = col_e;
        pslot_nxt = slot_e;
        prows_nxt = rows_e;
        rows_nxt  = rows_e;
        slot_nxt  = slot_e;
        if (fover_r) begin
          fover_nxt = 1'b0;
          dleft_nxt = 12'd0;
          drow_nxt  = 2'd0;
          ocol_nxt  = 10'd0;
        end
        if (last) begin
          col_nxt = 10'd0;
          if (in_end_of_frame) begin
            fover_nxt = 1'b1;
            drow_nxt  = rows_dr - 2'd1;
            dleft_nxt = drain_total;
            ocol_nxt  = 10'd0;
          end else begin
            if (rows_e != 3'd7) rows_nxt = rows_e + 3'd1;
            slot_nxt = (slot_e == 3'(scf_pkg::KSIZE - 1)) ? 3'd0 : slot_e + 3'd1;
          end
        end else begin
          col_nxt = c_inc[9:0];
        end
      end else if (dleft_r != 12'd0) begin
        dleft_nxt = dleft_r - 12'd1;
        if (ocol_inc >= width) begin
          ocol_nxt = 10'd0;
          if (drow_r != 2'd0) drow_nxt = drow_r - 2'd1;
        end else begin
          ocol_nxt = ocol_inc[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      col_r   <= '0;
      rows_r  <= '0;
      slot_r  <= '0;
      ocol_r  <= '0;
      dleft_r <= '0;
      drow_r  <= '0;
      fover_r <= 1'b0;
      busy_r  <= 1'b0;
      ps_r    <= '0;
      psmax_r <= '0;
    end else begin
      win_r   <= win_nxt;
      col_r   <= col_nxt;
      rows_r  <= rows_nxt;
      slot_r  <= slot_nxt;
      ocol_r  <= ocol_nxt;
      dleft_r <= dleft_nxt;
      drow_r  <= drow_nxt;
      fover_r <= fover_nxt;
      busy_r  <= busy_nxt;
      ps_r    <= ps_nxt;
      psmax_r <= psmax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r    <= pc_nxt;
    pslot_r <= pslot_nxt;
    prows_r <= prows_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/scf_job_queue.sv =====
// Four-entry job queue between front and back end.
`default_nettype none
module scf_job_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_push,
  input  scf_pkg::job_t      q_wjob,
  output logic               q_full,
  input  wire logic          q_pop,
  output scf_pkg::job_t      q_rjob,
  output logic               q_empty
);

  scf_pkg::job_t ent_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign q_full  = cnt_r == 3'd4;
  assign q_empty = cnt_r == 3'd0;
  assign q_rjob  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_push) wp_nxt = wp_r + 2'd1;
    if (q_pop)  rp_nxt = rp_r + 2'd1;
    case ({q_push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 3'd1;
      2'b01:   cnt_nxt = cnt_r - 3'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) ent_r[wp_r] <= q_wjob;
  end

endmodule
`default_nettype wire

// ===== rtl/core/scf_back.sv =====
// Back end: shared accumulator, line store and result queue.
`default_nettype none
`include "separable_convolution_filter_assert.svh"
module scf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  scf_pkg::tap_vec_t    taps,
  input  wire logic            q_empty,
  input  scf_pkg::job_t        q_job,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [7:0]           out_pixel_out,
  output logic                 out_run_last,
  output logic                 out_frame_last
);

  scf_pkg::back_state_t state_r, state_nxt;
  scf_pkg::job_t job_r, job_nxt;
  logic [2:0]  vi_r, vi_nxt, vi_m1;
  logic signed [37:0] acc_r, acc_nxt;

  logic [17:0] mem [scf_pkg::STORE_DEPTH];
  logic [17:0] rd_q;
  logic        mem_we;
  logic [12:0] waddr, raddr;
  logic [17:0] wdata;

  logic signed [24:0] hmul;
  logic signed [33:0] vmul;
  logic signed [37:0] hr, vr;
  logic [3:0]  jsum, jv, tsum;
  logic [2:0]  slot_rd;
  logic [7:0]  vpix;

  scf_pkg::out_word_t oq_r [4];
  logic [1:0] owp_r, orp_r;
  logic [2:0] ocnt_r, ocnt_nxt;
  logic       ofull, opush, opop;

  assign vi_m1 = vi_r - 3'd1;
  assign hmul  = $signed(taps[vi_r]) * $signed({1'b0, job_r.hpix[vi_r]});
  assign vmul  = $signed(taps[vi_m1]) * $signed(rd_q);
  assign hr    = (acc_r + 38'sd32) >>> 6;
  assign vr    = (acc_r + 38'sd2097152) >>> 22;

  always_comb begin
    if (hr > 38'sd131071)       wdata = 18'h1FFFF;
    else if (hr < -38'sd131072) wdata = 18'h20000;
    else                        wdata = hr[17:0];
    if (vr < 38'sd0)            vpix = 8'd0;
    else if (vr > 38'sd255)     vpix = 8'd255;
    else                        vpix = vr[7:0];
  end

  // source row: base + 3 - tap, clamped to 0..top, then counted back from slot
  always_comb begin
    jsum = {2'b00, job_r.base} + 4'd3;
    if (jsum < {1'b0, vi_r}) jv = 4'd0;
    else                     jv = jsum - {1'b0, vi_r};
    if (jv > {1'b0, job_r.top}) jv = {1'b0, job_r.top};
    tsum = {1'b0, job_r.slot} + 4'd7 - jv;
    if (tsum >= 4'd7) tsum = tsum - 4'd7;
    slot_rd = tsum[2:0];
  end

  assign waddr = {job_r.slot, job_r.x};
  assign raddr = {slot_rd, job_r.x};

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    vi_nxt    = vi_r;
    acc_nxt   = acc_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    opush     = 1'b0;
    case (state_r)
      scf_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          acc_nxt   = '0;
          vi_nxt    = 3'd0;
          state_nxt = q_job.do_h ? scf_pkg::B_HMAC : scf_pkg::B_VMAC;
        end
      end
      scf_pkg::B_HMAC: begin
        acc_nxt = acc_r + 38'(hmul);
        if (vi_r == 3'(scf_pkg::KSIZE - 1)) begin
          vi_nxt    = 3'd0;
          state_nxt = scf_pkg::B_HWR;
        end else begin
          vi_nxt = vi_r + 3'd1;
        end
      end
      scf_pkg::B_HWR: begin
        mem_we    = 1'b1;
        acc_nxt   = '0;
        vi_nxt    = 3'd0;
        state_nxt = job_r.do_v ? scf_pkg::B_VMAC : scf_pkg::B_IDLE;
      end
      scf_pkg::B_VMAC: begin
        // read for tap vi issued now, product of tap vi-1 added now
        if (vi_r != 3'd0) acc_nxt = acc_r + 38'(vmul);
        if (vi_r == 3'(scf_pkg::KSIZE)) state_nxt = scf_pkg::B_VOUT;
        else                            vi_nxt = vi_r + 3'd1;
      end
      scf_pkg::B_VOUT: begin
        if (!ofull) begin
          opush     = 1'b1;
          state_nxt = scf_pkg::B_IDLE;
        end
      end
      default: state_nxt = scf_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scf_pkg::B_IDLE;
      vi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vi_r    <= vi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // result queue
  assign ofull = ocnt_r == 3'd4;
  assign empty = ocnt_r == 3'd0;
  assign opop  = pop & ~empty;
  assign out_pixel_out  = oq_r[orp_r].pixel;
  assign out_run_last   = oq_r[orp_r].run_last;
  assign out_frame_last = oq_r[orp_r].frame_last;

  always_comb begin
    case ({opush, opop})
      2'b10:   ocnt_nxt = ocnt_r + 3'd1;
      2'b01:   ocnt_nxt = ocnt_r - 3'd1;
      default: ocnt_nxt = ocnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 2'd1;
      if (opop)  orp_r <= orp_r + 2'd1;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owp_r] <= '{pixel: vpix, run_last: job_r.run_last,
                                frame_last: job_r.frame_last};
  end

  `SCF_ASSERT_IMP(a_hwr_after_hmac, clk, rst_n, state_r == scf_pkg::B_HWR, $past(state_r) == scf_pkg::B_HMAC, "store write without row sum")
  `SCF_ASSERT_NXT(a_pop_starts_job, clk, rst_n, q_pop, state_r != scf_pkg::B_IDLE, "job popped but not started")
  `SCF_ASSERT_IMP(a_no_out_overflow, clk, rst_n, opush, ocnt_r != 3'd4, "result queue overflow")

endmodule
`default_nettype wire
